// ===== hdl/p25519_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package p25519_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned NWORDS = 8;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned ACC_W  = 68;   // column sum: 8 products plus carry-in
    localparam int unsigned CRY_W  = 11;   // fold carry, up to 39 * 38

    localparam logic [5:0] FOLD38 = 6'd38;
    localparam logic [4:0] FOLD19 = 5'd19;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_CLR,      // clear column accumulator and fold carry
        DP_PUSH,     // push low word of accumulator into product line
        DP_FOLD,     // one word step: carry + lo + 38 * hi
        DP_LOAD38,   // carry <= carry * 38
        DP_TOP,      // clear bit 255, carry <= 19 * old bit
        DP_SHOUT     // shift result words down after an output item
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic              wr_en;
        logic              mac_vld;
        logic              mac_last;
        logic [IDX_W-1:0]  mac_i;
        logic [IDX_W-1:0]  mac_j;
    } dp_cmd_t;

    typedef struct packed {
        logic carry_nz;
        logic top_bit;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/mod_p25519_mul_weak_reduce.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Multiplier modulo 2^255-19 with weak reduction.
// Input channel (s_*): one item per operand word pair; tdata carries the word
// index and one word each of a and b, tuser the mode (0 a*b, 1 a*a), tlast
// marks the final word, which starts the computation. The op of that item
// decides the mode. Slots not rewritten keep their earlier words.
// Result channel (m_*): eight items, word 0 first, tlast on word 7. Bit 255
// of the result is clear; the value may still lie in [p, 2^255).
// Timing: load items are accepted whenever the block is idle. After the last
// item the 64 word products run through the single 32x32 multiplier, one a
// cycle, 3-stage pipe; then word-serial fold passes over the eight words
// (3 to 5 passes). The result words then go out at one per cycle while the
// receiver is ready.
// s_tready is low from the last input item until the eighth result is taken.
// A stalled receiver just holds the current result word; nothing is lost.
// Reset (aresetn low, synchronous) returns to idle and drops pending
// results; operand words are not cleared.
module mod_p25519_mul_weak_reduce (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // word_index[2:0], a_word[34:3], b_word[66:35], pad
    input  wire logic [0:0]  s_tuser,   // op
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // result_word[31:0], result_index[34:32], pad
    output logic             m_tlast
);

    p25519_pkg::dp_cmd_t  cmd;
    p25519_pkg::dp_stat_t stat;
    logic [p25519_pkg::WORD_W-1:0] res_word;
    logic [p25519_pkg::IDX_W-1:0]  res_idx;

    p25519_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .res_idx  (res_idx),
        .cmd      (cmd),
        .stat     (stat)
    );

    p25519_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .wr_idx   (s_tdata[2:0]),
        .wr_a     (s_tdata[34:3]),
        .wr_b     (s_tdata[66:35]),
        .wr_sq    (s_tuser[0]),
        .stat     (stat),
        .res_word (res_word)
    );

    assign m_tdata = {5'd0, res_idx, res_word};

endmodule
`default_nettype wire

// ===== hdl/p25519_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module p25519_dp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire p25519_pkg::dp_cmd_t                 cmd,
    input  wire logic [p25519_pkg::IDX_W-1:0]        wr_idx,
    input  wire logic [p25519_pkg::WORD_W-1:0]       wr_a,
    input  wire logic [p25519_pkg::WORD_W-1:0]       wr_b,
    input  wire logic                                wr_sq,
    output p25519_pkg::dp_stat_t                     stat,
    output logic [p25519_pkg::WORD_W-1:0]            res_word
);

    localparam int unsigned W = p25519_pkg::WORD_W;

    logic [W-1:0] a_mem [p25519_pkg::NWORDS];
    logic [W-1:0] b_mem [p25519_pkg::NWORDS];
    logic         sq_reg;

    logic [W-1:0] x_reg, y_reg;
    logic         v1_reg, l1_reg, v2_reg, l2_reg;
    logic [2*W-1:0] prod_reg;
    logic [p25519_pkg::ACC_W-1:0] acc_reg;
    logic [p25519_pkg::ACC_W-1:0] acc_sum;
    logic [p25519_pkg::CRY_W-1:0] carry_reg;
    logic [W-1:0] p_reg [2*p25519_pkg::NWORDS];
    logic [39:0]  fold_sum;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            a_mem[wr_idx] <= wr_a;
            b_mem[wr_idx] <= wr_b;
        end
        x_reg <= a_mem[cmd.mac_i];
        y_reg <= sq_reg ? a_mem[cmd.mac_j] : b_mem[cmd.mac_j];
        prod_reg <= x_reg * y_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg <= 1'b0;
            v1_reg <= 1'b0;
            l1_reg <= 1'b0;
            v2_reg <= 1'b0;
            l2_reg <= 1'b0;
        end else begin
            if (cmd.wr_en) begin
                sq_reg <= wr_sq;
            end
            v1_reg <= cmd.mac_vld;
            l1_reg <= cmd.mac_last;
            v2_reg <= v1_reg;
            l2_reg <= l1_reg;
        end
    end

    assign acc_sum  = acc_reg + p25519_pkg::ACC_W'(prod_reg);
    assign fold_sum = 40'(carry_reg) + 40'(p_reg[0])
                    + 40'(p_reg[p25519_pkg::NWORDS]) * 40'(p25519_pkg::FOLD38);

    always_ff @(posedge aclk) begin
        if (v2_reg) begin
            if (l2_reg) begin
                for (int k = 0; k < 15; k++) p_reg[k] <= p_reg[k+1];
                p_reg[15] <= acc_sum[W-1:0];
                acc_reg   <= acc_sum >> W;
            end else begin
                acc_reg <= acc_sum;
            end
        end else begin
            case (cmd.op)
                p25519_pkg::DP_CLR: begin
                    acc_reg   <= '0;
                    carry_reg <= '0;
                end
                p25519_pkg::DP_PUSH: begin
                    for (int k = 0; k < 15; k++) p_reg[k] <= p_reg[k+1];
                    p_reg[15] <= acc_reg[W-1:0];
                end
                p25519_pkg::DP_FOLD: begin
                    for (int k = 0; k < 7; k++) p_reg[k] <= p_reg[k+1];
                    p_reg[7] <= fold_sum[W-1:0];
                    for (int k = 8; k < 15; k++) p_reg[k] <= p_reg[k+1];
                    p_reg[15] <= '0;
                    carry_reg <= p25519_pkg::CRY_W'(fold_sum[39:W]);
                end
                p25519_pkg::DP_LOAD38: begin
                    carry_reg <= p25519_pkg::CRY_W'(carry_reg[5:0])
                               * p25519_pkg::CRY_W'(p25519_pkg::FOLD38);
                end
                p25519_pkg::DP_TOP: begin
                    p_reg[7][W-1] <= 1'b0;
                    carry_reg <= p_reg[7][W-1] ? p25519_pkg::CRY_W'(p25519_pkg::FOLD19)
                                               : '0;
                end
                p25519_pkg::DP_SHOUT: begin
                    for (int k = 0; k < 7; k++) p_reg[k] <= p_reg[k+1];
                end
                default: begin
                end
            endcase
        end
    end

    assign stat.carry_nz = (carry_reg != '0);
    assign stat.top_bit  = p_reg[7][W-1];
    assign res_word      = p_reg[0];

endmodule
`default_nettype wire

// ===== hdl/p25519_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module p25519_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tlast,
    output logic                               s_tready,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic                               m_tlast,
    output logic [p25519_pkg::IDX_W-1:0]       res_idx,
    output p25519_pkg::dp_cmd_t                cmd,
    input  wire p25519_pkg::dp_stat_t          stat
);

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_DRAIN, S_PUSH, S_FOLD, S_LD1, S_ADD1, S_LD2, S_ADD2,
        S_TOP1, S_TP1, S_TOP2, S_TP2, S_OUT
    } state_t;

    state_t      state_reg;
    logic [3:0]  k_reg;
    logic [2:0]  i_reg;
    logic [2:0]  cnt_reg;
    logic        mv_reg;
    logic [2:0]  ri_reg;
    logic [2:0]  hi_i, lo_next;
    logic        s_acc, m_acc;

    assign hi_i    = (k_reg > 4'd7) ? 3'd7 : k_reg[2:0];
    assign lo_next = (k_reg >= 4'd6) ? 3'(k_reg - 4'd6) : 3'd0;
    assign s_acc   = s_tvalid && s_tready;
    assign m_acc   = mv_reg && m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tlast  = (ri_reg == 3'd7);
    assign res_idx  = ri_reg;

    always_comb begin
        cmd          = '0;
        cmd.op       = p25519_pkg::DP_NOP;
        cmd.mac_i    = i_reg;
        cmd.mac_j    = 3'(k_reg - {1'b0, i_reg});
        unique case (state_reg)
            S_IDLE: begin
                cmd.wr_en = s_acc;
                if (s_acc && s_tlast) cmd.op = p25519_pkg::DP_CLR;
            end
            S_MAC: begin
                cmd.mac_vld  = 1'b1;
                cmd.mac_last = (i_reg == hi_i);
            end
            S_PUSH:  cmd.op = p25519_pkg::DP_PUSH;
            S_FOLD, S_ADD1, S_ADD2, S_TP1, S_TP2: cmd.op = p25519_pkg::DP_FOLD;
            S_LD1:   cmd.op = p25519_pkg::DP_LOAD38;
            S_LD2:   if (stat.carry_nz) cmd.op = p25519_pkg::DP_LOAD38;
            S_TOP1:  cmd.op = p25519_pkg::DP_TOP;
            S_TOP2:  if (stat.top_bit) cmd.op = p25519_pkg::DP_TOP;
            S_OUT:   if (m_acc) cmd.op = p25519_pkg::DP_SHOUT;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            i_reg     <= '0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
            ri_reg    <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc && s_tlast) begin
                        k_reg     <= '0;
                        i_reg     <= '0;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (i_reg == hi_i) begin
                        k_reg <= k_reg + 4'd1;
                        i_reg <= lo_next;
                        if (k_reg == 4'd14) begin
                            cnt_reg   <= '0;
                            state_reg <= S_DRAIN;
                        end
                    end else begin
                        i_reg <= i_reg + 3'd1;
                    end
                end
                S_DRAIN: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd2) state_reg <= S_PUSH;
                end
                S_PUSH: begin
                    cnt_reg   <= '0;
                    state_reg <= S_FOLD;
                end
                S_FOLD, S_ADD1, S_ADD2, S_TP1, S_TP2: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7) begin
                        unique case (state_reg)
                            S_FOLD:  state_reg <= S_LD1;
                            S_ADD1:  state_reg <= S_LD2;
                            S_ADD2:  state_reg <= S_TOP1;
                            S_TP1:   state_reg <= S_TOP2;
                            default: begin
                                mv_reg    <= 1'b1;
                                ri_reg    <= '0;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_LD1:  state_reg <= S_ADD1;
                S_LD2:  state_reg <= stat.carry_nz ? S_ADD2 : S_TOP1;
                S_TOP1: state_reg <= S_TP1;
                S_TOP2: begin
                    if (stat.top_bit) begin
                        state_reg <= S_TP2;
                    end else begin
                        mv_reg    <= 1'b1;
                        ri_reg    <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_acc) begin
                        ri_reg <= ri_reg + 3'd1;
                        if (ri_reg == 3'd7) begin
                            mv_reg    <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_valid_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg |-> (state_reg == S_OUT))
        else $error("result valid outside output phase");

    a_mac_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAC) |-> ({1'b0, i_reg} <= k_reg && (k_reg - {1'b0, i_reg}) <= 4'd7))
        else $error("operand index out of range");

    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && m_tready && ri_reg == 3'd7) |=> (s_tready && !mv_reg))
        else $error("not back to idle after last result");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && mv_reg))
        else $error("input taken while results pending");

endmodule
`default_nettype wire
